FILE: hdl/irke_pkg.sv
`default_nettype none
// ============================================================================
// irke_pkg: shared types and constants of the IR remote key event generator
// Holds the keymap geometry, register indexes, item codes and the packed
// payload structs used by the front end, the job queue and the back end.
// ============================================================================
package irke_pkg;

    // Keymap geometry.
    localparam int unsigned MAP_COUNT    = 32;
    localparam int unsigned KEYS_PER_MAP = 128;
    localparam int unsigned MAP_DEPTH    = MAP_COUNT * KEYS_PER_MAP;
    localparam int unsigned MEM_AW       = $clog2(MAP_DEPTH);

    // Field widths.
    localparam int unsigned KEYCODE_W = 10;
    localparam int unsigned ADDR_W    = 5;
    localparam int unsigned DATA_W    = 7;
    localparam int unsigned COUNT_W   = 16;

    // Result buffer of the back end: at most five results per item.
    localparam int unsigned MAX_RES = 5;
    localparam int unsigned RES_IW  = $clog2(MAX_RES);
    localparam int unsigned RES_CW  = $clog2(MAX_RES + 1);

    // Job queue between front and back end.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned Q_AW        = $clog2(QUEUE_DEPTH);

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYUP_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDR_ENABLE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTOCOL_MODE = 2'd3;

    // Configuration reset values.
    localparam logic [15:0] RST_KEYUP_TIMEOUT = 16'd280;
    localparam logic [15:0] RST_REPEAT_DELAY  = 16'd250;
    localparam logic [31:0] RST_ADDR_ENABLE   = 32'hFFFF_FFFF;
    localparam logic [7:0]  RST_PROTOCOL_MODE = 8'd0;

    // Input item kinds.
    localparam logic [1:0] KIND_CMD   = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    // Queued job operations.
    localparam logic [1:0] OP_CMD   = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Result kinds.
    localparam logic [2:0] EV_KEY  = 3'd0;
    localparam logic [2:0] EV_RAW  = 3'd1;
    localparam logic [2:0] EV_SCAN = 3'd2;
    localparam logic [2:0] EV_SYNC = 3'd3;
    localparam logic [2:0] EV_OLD  = 3'd4;

    // Key event values.
    localparam logic [31:0] KEY_RELEASE = 32'd0;
    localparam logic [31:0] KEY_PRESS   = 32'd1;
    localparam logic [31:0] KEY_REPEAT  = 32'd2;

    // Command word bit positions.
    localparam int unsigned CMD_CEC_BIT    = 31;
    localparam int unsigned CMD_FIELD_BIT  = 12;
    localparam int unsigned CMD_TOGGLE_BIT = 11;
    localparam int unsigned CMD_ADDR_LSB   = 6;

    typedef struct packed {
        logic [1:0]           kind;
        logic [31:0]          command;
        logic [ADDR_W-1:0]    map_address;
        logic [DATA_W-1:0]    map_index;
        logic [KEYCODE_W-1:0] new_keycode;
    } t_in_item;

    typedef struct packed {
        logic [2:0]           event_kind;
        logic [KEYCODE_W-1:0] event_code;
        logic [31:0]          event_value;
        logic                 last;
    } t_out_item;

    typedef struct packed {
        logic [15:0] keyup_timeout;
        logic [15:0] repeat_delay;
        logic [31:0] addr_enable;
        logic [7:0]  protocol_mode;
    } t_cfg;

    // A classified item as it waits for the back end.
    typedef struct packed {
        logic [1:0]           op;
        logic [31:0]          raw;
        logic [ADDR_W-1:0]    addr;
        logic [DATA_W-1:0]    data;
        logic                 toggle;
        logic                 in_map;
        logic                 hit;
        logic [KEYCODE_W-1:0] new_keycode;
    } t_job;

endpackage
`default_nettype wire

FILE: hdl/irke_front.sv
`default_nettype none
// ============================================================================
// irke_front: input classifier
// Splits command words into address, data and toggle, resolves the keymap
// gating and drops items that have no effect before they reach the queue.
// ============================================================================
module irke_front (
    input  wire irke_pkg::t_in_item i_item,
    input  wire                     i_push,
    input  wire irke_pkg::t_cfg     i_cfg,
    input  wire                     i_q_full,
    input  wire                     i_clearing,
    output logic                    o_full,
    output logic                    o_q_push,
    output irke_pkg::t_job          o_q_job
);
    import irke_pkg::*;

    logic              cec;
    logic              keep;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;

    assign cec = i_item.command[CMD_CEC_BIT];

    always_comb begin
        keep        = 1'b0;
        o_q_job.op  = OP_TICK;
        o_q_job.raw = i_item.command;
        o_q_job.toggle      = 1'b0;
        o_q_job.new_keycode = i_item.new_keycode;
        addr = '0;
        data = '0;
        unique case (i_item.kind)
            KIND_CMD: begin
                o_q_job.op = OP_CMD;
                // Non-CEC words are only understood in extended RC5 mode.
                keep = cec || (i_cfg.protocol_mode == 8'd0);
                if (cec) begin
                    data = i_item.command[DATA_W-1:0];
                end else begin
                    addr = i_item.command[CMD_ADDR_LSB +: ADDR_W];
                    data = {~i_item.command[CMD_FIELD_BIT], i_item.command[5:0]};
                    o_q_job.toggle = i_item.command[CMD_TOGGLE_BIT];
                end
            end
            KIND_TICK: begin
                keep = 1'b1;
            end
            KIND_WRITE: begin
                o_q_job.op = OP_WRITE;
                keep = 1'b1;
                addr = i_item.map_address;
                data = i_item.map_index;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
        o_q_job.addr   = addr;
        o_q_job.data   = data;
        o_q_job.in_map = int'(addr) < MAP_COUNT;
        o_q_job.hit    = o_q_job.in_map &&
                         ((o_q_job.op == OP_WRITE) || i_cfg.addr_enable[addr]);
    end

    assign o_full   = i_q_full || i_clearing;
    assign o_q_push = i_push && !o_full && keep;

endmodule
`default_nettype wire

FILE: hdl/irke_queue.sv
`default_nettype none
// ============================================================================
// irke_queue: job queue
// Short first-in first-out buffer between the classifier and the back end.
// ============================================================================
module irke_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  wire irke_pkg::t_job i_job,
    output logic                o_full,
    input  wire                 i_pop,
    output irke_pkg::t_job      o_job,
    output logic                o_empty
);
    import irke_pkg::*;

    t_job            r_slot [QUEUE_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_AW:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == (Q_AW + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_job;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/irke_back.sv
`default_nettype none
// ============================================================================
// irke_back: keymap and key state engine
// Reads the keymap for the queued job, updates the key-up and repeat state
// and hands the job's results out one at a time from a small buffer.
// ============================================================================
module irke_back (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire irke_pkg::t_cfg     i_cfg,
    input  wire                     i_q_empty,
    input  wire irke_pkg::t_job     i_q_job,
    output logic                    o_q_pop,
    output logic                    o_empty,
    input  wire                     i_pop,
    output irke_pkg::t_out_item     o_out,
    output logic                    o_clearing
);
    import irke_pkg::*;

    // Keymap memory and its clearing pass.
    logic [KEYCODE_W-1:0] r_mem [MAP_DEPTH];
    logic [KEYCODE_W-1:0] r_rdata;
    logic                 r_clr_busy;
    logic [MEM_AW-1:0]    r_clr_addr;
    logic                 mem_we;
    logic [MEM_AW-1:0]    mem_waddr;
    logic [MEM_AW-1:0]    mem_raddr;
    logic [KEYCODE_W-1:0] mem_wdata;

    // Job held while its keymap data is read.
    logic r_a_valid;
    t_job r_a_job;

    // Key state.
    logic [KEYCODE_W-1:0] r_last_key,      n_last_key;
    logic                 r_last_toggle,   n_last_toggle;
    logic                 r_key_down,      n_key_down;
    logic                 r_keyup_active,  n_keyup_active;
    logic [COUNT_W-1:0]   r_keyup_count,   n_keyup_count;
    logic                 r_repeat_active, n_repeat_active;
    logic [COUNT_W-1:0]   r_repeat_count,  n_repeat_count;
    logic                 r_repeat_ready,  n_repeat_ready;

    // Result buffer.
    logic              r_b_valid;
    t_out_item         r_res [MAX_RES];
    logic [RES_CW-1:0] r_cnt;
    logic [RES_IW-1:0] r_idx;
    t_out_item         n_res [MAX_RES];
    logic [RES_CW-1:0] n_cnt;

    logic b_free;
    logic eval_fire;
    logic a_free;

    function automatic t_out_item mk(input logic [2:0] k,
                                     input logic [KEYCODE_W-1:0] c,
                                     input logic [31:0] v);
        t_out_item r;
        r.event_kind  = k;
        r.event_code  = c;
        r.event_value = v;
        r.last        = 1'b0;
        return r;
    endfunction

    assign b_free    = !r_b_valid || (i_pop && (RES_CW'(r_idx) == r_cnt - 1'b1));
    assign eval_fire = r_a_valid && b_free;
    assign a_free    = !r_a_valid || eval_fire;
    assign o_q_pop   = !i_q_empty && a_free;

    assign mem_raddr = MEM_AW'({i_q_job.addr, i_q_job.data});
    assign mem_we    = r_clr_busy ||
                       (eval_fire && (r_a_job.op == OP_WRITE) && r_a_job.in_map);
    assign mem_waddr = r_clr_busy ? r_clr_addr : MEM_AW'({r_a_job.addr, r_a_job.data});
    assign mem_wdata = r_clr_busy ? '0 : r_a_job.new_keycode;

    // The read for the next job may meet the write of the job ahead of it;
    // the fresh value is forwarded in that case.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (o_q_pop) begin
            r_rdata <= (mem_we && (mem_waddr == mem_raddr)) ? mem_wdata : r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_a_job <= i_q_job;
        end
    end

    always_comb begin
        logic [KEYCODE_W-1:0] kc;
        logic                 send;
        logic [RES_CW-1:0]    n;
        n_last_key      = r_last_key;
        n_last_toggle   = r_last_toggle;
        n_key_down      = r_key_down;
        n_keyup_active  = r_keyup_active;
        n_keyup_count   = r_keyup_count;
        n_repeat_active = r_repeat_active;
        n_repeat_count  = r_repeat_count;
        n_repeat_ready  = r_repeat_ready;
        for (int i = 0; i < MAX_RES; i++) begin
            n_res[i] = '0;
        end
        n    = '0;
        send = 1'b1;
        kc   = r_a_job.hit ? r_rdata : '0;
        if (eval_fire) begin
            unique case (r_a_job.op)
                OP_CMD: begin
                    if (r_keyup_active) begin
                        if ((r_last_key != kc) || (r_a_job.toggle != r_last_toggle)) begin
                            n_res[n[RES_IW-1:0]] = mk(EV_KEY, r_last_key, KEY_RELEASE);
                            n = n + 1'b1;
                            n_key_down      = 1'b0;
                            n_repeat_active = 1'b0;
                        end else if (r_repeat_ready) begin
                            n_res[n[RES_IW-1:0]] = mk(EV_KEY, kc, KEY_REPEAT);
                            n = n + 1'b1;
                            send = 1'b0;
                        end else begin
                            send = 1'b0;
                        end
                    end
                    if (send) begin
                        n_res[n[RES_IW-1:0]] = mk(EV_RAW, '0, r_a_job.raw);
                        n = n + 1'b1;
                        n_res[n[RES_IW-1:0]] = mk(EV_SCAN, '0,
                            {11'd0, r_a_job.addr, 9'd0, r_a_job.data});
                        n = n + 1'b1;
                        if (kc != '0) begin
                            n_repeat_ready = 1'b0;
                            n_res[n[RES_IW-1:0]] = mk(EV_KEY, kc, KEY_PRESS);
                            n = n + 1'b1;
                            n_key_down      = 1'b1;
                            n_repeat_active = 1'b1;
                            n_repeat_count  = i_cfg.repeat_delay;
                        end
                    end
                    n_res[n[RES_IW-1:0]] = mk(EV_SYNC, '0, '0);
                    n = n + 1'b1;
                    n_keyup_active = 1'b0;
                    if (kc != '0) begin
                        n_last_key     = kc;
                        n_last_toggle  = r_a_job.toggle;
                        n_keyup_active = 1'b1;
                        n_keyup_count  = i_cfg.keyup_timeout;
                    end
                end
                OP_TICK: begin
                    // Key-up countdown first; its release also stops the
                    // repeat countdown.
                    if (r_keyup_active) begin
                        if (r_keyup_count <= COUNT_W'(1)) begin
                            n_keyup_active = 1'b0;
                            n_keyup_count  = '0;
                            if (r_key_down) begin
                                n_res[n[RES_IW-1:0]] = mk(EV_KEY, r_last_key, KEY_RELEASE);
                                n = n + 1'b1;
                                n_key_down      = 1'b0;
                                n_repeat_active = 1'b0;
                                n_res[n[RES_IW-1:0]] = mk(EV_SYNC, '0, '0);
                                n = n + 1'b1;
                            end
                        end else begin
                            n_keyup_count = r_keyup_count - 1'b1;
                        end
                    end
                    if (n_repeat_active) begin
                        if (r_repeat_count <= COUNT_W'(1)) begin
                            n_repeat_active = 1'b0;
                            n_repeat_count  = '0;
                            n_repeat_ready  = 1'b1;
                        end else begin
                            n_repeat_count = r_repeat_count - 1'b1;
                        end
                    end
                end
                OP_WRITE: begin
                    n_res[n[RES_IW-1:0]] = mk(EV_OLD, '0,
                        r_a_job.in_map ? {22'd0, r_rdata} : 32'd0);
                    n = n + 1'b1;
                end
                default: begin
                    n = '0;
                end
            endcase
            if (n != '0) begin
                n_res[RES_IW'(n - 1'b1)].last = 1'b1;
            end
        end
        n_cnt = n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy      <= 1'b1;
            r_clr_addr      <= '0;
            r_a_valid       <= 1'b0;
            r_b_valid       <= 1'b0;
            r_idx           <= '0;
            r_cnt           <= '0;
            r_last_key      <= '0;
            r_last_toggle   <= 1'b0;
            r_key_down      <= 1'b0;
            r_keyup_active  <= 1'b0;
            r_keyup_count   <= '0;
            r_repeat_active <= 1'b0;
            r_repeat_count  <= '0;
            r_repeat_ready  <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == MEM_AW'(MAP_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (o_q_pop) begin
                r_a_valid <= 1'b1;
            end else if (eval_fire) begin
                r_a_valid <= 1'b0;
            end
            if (r_b_valid && i_pop) begin
                if (RES_CW'(r_idx) == r_cnt - 1'b1) begin
                    r_b_valid <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (eval_fire && (n_cnt != '0)) begin
                r_b_valid <= 1'b1;
                r_idx     <= '0;
                r_cnt     <= n_cnt;
            end
            r_last_key      <= n_last_key;
            r_last_toggle   <= n_last_toggle;
            r_key_down      <= n_key_down;
            r_keyup_active  <= n_keyup_active;
            r_keyup_count   <= n_keyup_count;
            r_repeat_active <= n_repeat_active;
            r_repeat_count  <= n_repeat_count;
            r_repeat_ready  <= n_repeat_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eval_fire && (n_cnt != '0)) begin
            r_res <= n_res;
        end
    end

    assign o_empty    = !r_b_valid;
    assign o_out      = r_res[r_idx];
    assign o_clearing = r_clr_busy;

endmodule
`default_nettype wire

FILE: hdl/ir_remote_key_event_generator_core.sv
`default_nettype none
// ============================================================================
// ir_remote_key_event_generator_core: IR remote key event generator
// Turns received RC5/CEC command words, time ticks and keymap writes into
// press, repeat and release key events, raw, scan and sync records and old keymap entries.
// ============================================================================
//
//  Channel   Handshake                 Payload
//  -------   -----------------------   ------------------------------------
//  input     push / full               i_in  (kind, command, keymap entry)
//  result    pop / empty               o_out (event kind, code, value, last)
//  config    i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// An item is accepted every cycle while the four-entry job queue has room
// and the keymap is not being cleared. The back end takes one job per cycle
// while its result buffer is free: a command leaves one to five results,
// one per transfer, and the next job is evaluated once the last of them is
// popped; a tick with no results leaves the buffer free, and a dropped
// command is accepted but never enters the queue. The keymap memory port
// reads one entry per job as the job leaves the queue and holds it until
// the job is evaluated. After reset a clearing pass zeroes all 4096 keymap
// entries, one entry per cycle, and full stays high meanwhile; configuration
// writes are taken on every cycle once o_cfg_ready is high. Either side
// may stall without holding up the other until the queue or result buffer fills.
//
module ir_remote_key_event_generator_core (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    // Input queue side.
    input  wire                       push,
    output logic                      full,
    input  wire irke_pkg::t_in_item   i_in,
    // Result queue side.
    output logic                      empty,
    input  wire                       pop,
    output irke_pkg::t_out_item       o_out,
    // Configuration write channel.
    input  wire                       i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire [irke_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire [31:0]                i_cfg_data
);
    import irke_pkg::*;

    t_cfg r_cfg;
    logic r_cfg_ready;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    t_job q_in_job;
    t_job q_out_job;
    logic clearing;

    // Registers accept a write on every cycle once out of reset; the user must
    // change them only while the block is idle, which the block does not enforce;
    // the new values then take effect for the next item.
    assign o_cfg_ready = r_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ready         <= 1'b0;
            r_cfg.keyup_timeout <= RST_KEYUP_TIMEOUT;
            r_cfg.repeat_delay  <= RST_REPEAT_DELAY;
            r_cfg.addr_enable   <= RST_ADDR_ENABLE;
            r_cfg.protocol_mode <= RST_PROTOCOL_MODE;
        end else begin
            r_cfg_ready <= 1'b1;
            if (i_cfg_valid && r_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_KEYUP_TIMEOUT: r_cfg.keyup_timeout <= i_cfg_data[15:0];
                    CFG_REPEAT_DELAY:  r_cfg.repeat_delay  <= i_cfg_data[15:0];
                    CFG_ADDR_ENABLE:   r_cfg.addr_enable   <= i_cfg_data;
                    CFG_PROTOCOL_MODE: r_cfg.protocol_mode <= i_cfg_data[7:0];
                    default:           r_cfg.protocol_mode <= r_cfg.protocol_mode;
                endcase
            end
        end
    end

    // The classifier decodes each item and drops those with no effect.
    irke_front u_front (
        .i_item     (i_in),
        .i_push     (push),
        .i_cfg      (r_cfg),
        .i_q_full   (q_full),
        .i_clearing (clearing),
        .o_full     (full),
        .o_q_push   (q_push),
        .o_q_job    (q_in_job)
    );

    // The job queue decouples acceptance from evaluation.
    irke_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (q_out_job),
        .o_empty (q_empty)
    );

    // The back end owns the keymap and the key state and serializes results.
    irke_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_empty  (q_empty),
        .i_q_job    (q_out_job),
        .o_q_pop    (q_pop),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_out      (o_out),
        .o_clearing (clearing)
    );

    // No item may enter while the keymap is being cleared.
    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> full)
        else $error("input accepted during keymap clearing pass");

    // A result that is not the last of its item is always followed by more.
    a_item_not_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_out.last) |=> !empty)
        else $error("results of one item were split by a gap");

    // Sync records and keymap replies always close their item.
    a_closing_kinds_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && ((o_out.event_kind == EV_SYNC) || (o_out.event_kind == EV_OLD)))
        |-> o_out.last)
        else $error("closing result without last flag");

    // Nothing can be waiting on the result side when the clearing pass ends.
    a_clear_ends_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(clearing) |-> empty)
        else $error("result present at end of keymap clearing pass");

endmodule
`default_nettype wire
